FILE: sv/mmbd_pkg.sv
// Shared constants and types for the min/max bucket decimator.
`timescale 1ns / 1ps
`default_nettype none
package mmbd_pkg;

   localparam int CNT_BITS      = 32;
   localparam int IDX_BITS      = 16;
   localparam int BS_BITS       = 25;
   localparam int NB_BITS       = 17;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 25;

   localparam logic [BS_BITS-1:0] BS_RESET = 25'd1024;
   localparam logic [NB_BITS-1:0] NB_RESET = 17'd1024;
   localparam logic [NB_BITS-1:0] NB_MAX   = 17'd65536;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_BUCKET_SIZE = 2'd0,
      CSR_NUM_BUCKETS = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic min_first;
      logic rec_end;
   } mmbd_flags_type;

endpackage
`default_nettype wire

FILE: sv/mmbd_front.sv
// Front end: configuration registers, running min/max tracking and bucket close detection.
`timescale 1ns / 1ps
`default_nettype none
module mmbd_front
   import mmbd_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int POS_BITS    = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_en,
   input  wire logic [CSR_IDX_BITS-1:0]       csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  wire logic                          accept,
   input  wire logic [POS_BITS-1:0]           x_pos,
   input  wire logic signed [SAMPLE_BITS-1:0] y_sample,
   input  wire logic                          record_end,
   output logic                               push,
   output logic [POS_BITS-1:0]                min_x,
   output logic signed [SAMPLE_BITS-1:0]      min_y,
   output logic [POS_BITS-1:0]                max_x,
   output logic signed [SAMPLE_BITS-1:0]      max_y,
   output mmbd_flags_type                     flags
);

   logic [BS_BITS-1:0]            bs_ff;
   logic [NB_BITS-1:0]            nb_ff;
   logic [IDX_BITS-1:0]           idx_ff;
   logic [IDX_BITS-1:0]           idx_in;
   logic [CNT_BITS-1:0]           cnt_ff;
   logic [CNT_BITS-1:0]           cnt_in;
   logic [CNT_BITS-1:0]           cnt_inc;
   logic signed [SAMPLE_BITS-1:0] min_v_ff;
   logic signed [SAMPLE_BITS-1:0] min_v_in;
   logic signed [SAMPLE_BITS-1:0] max_v_ff;
   logic signed [SAMPLE_BITS-1:0] max_v_in;
   logic [CNT_BITS-1:0]           min_p_ff;
   logic [CNT_BITS-1:0]           min_p_in;
   logic [CNT_BITS-1:0]           max_p_ff;
   logic [CNT_BITS-1:0]           max_p_in;
   logic [POS_BITS-1:0]           min_x_ff;
   logic [POS_BITS-1:0]           min_x_in;
   logic [POS_BITS-1:0]           max_x_ff;
   logic [POS_BITS-1:0]           max_x_in;
   logic [NB_BITS-1:0]            nb_wr;
   logic                          first;
   logic                          lt;
   logic                          gt;
   logic                          last_bucket;
   logic                          close;

   assign nb_wr = csr_wdata[NB_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff <= BS_RESET;
         nb_ff <= NB_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_BUCKET_SIZE: begin
               bs_ff <= (csr_wdata[BS_BITS-1:0] == '0) ? BS_BITS'(1) : csr_wdata[BS_BITS-1:0];
            end
            CSR_NUM_BUCKETS: begin
               if (nb_wr == '0) begin
                  nb_ff <= NB_BITS'(1);
               end else if (nb_wr > NB_MAX) begin
                  nb_ff <= NB_MAX;
               end else begin
                  nb_ff <= nb_wr;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      first   = (cnt_ff == '0);
      lt      = (y_sample < min_v_ff);
      gt      = (y_sample > max_v_ff);
      cnt_inc = (cnt_ff == '1) ? cnt_ff : cnt_ff + CNT_BITS'(1);

      min_v_in = min_v_ff;
      min_p_in = min_p_ff;
      min_x_in = min_x_ff;
      max_v_in = max_v_ff;
      max_p_in = max_p_ff;
      max_x_in = max_x_ff;
      if (first) begin
         min_v_in = y_sample;
         min_p_in = '0;
         min_x_in = x_pos;
         max_v_in = y_sample;
         max_p_in = '0;
         max_x_in = x_pos;
      end else begin
         if (lt) begin
            min_v_in = y_sample;
            min_p_in = cnt_ff;
            min_x_in = x_pos;
         end
         if (gt) begin
            max_v_in = y_sample;
            max_p_in = cnt_ff;
            max_x_in = x_pos;
         end
      end

      last_bucket = ({1'b0, idx_ff} + NB_BITS'(1)) >= nb_ff;
      close = record_end || (!last_bucket && (cnt_inc >= CNT_BITS'(bs_ff)));

      cnt_in = close ? '0 : cnt_inc;
      if (!close) begin
         idx_in = idx_ff;
      end else if (record_end) begin
         idx_in = '0;
      end else begin
         idx_in = idx_ff + IDX_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         min_v_ff <= min_v_in;
         min_p_ff <= min_p_in;
         min_x_ff <= min_x_in;
         max_v_ff <= max_v_in;
         max_p_ff <= max_p_in;
         max_x_ff <= max_x_in;
      end
   end

   assign push            = accept && close;
   assign min_x           = min_x_in;
   assign min_y           = min_v_in;
   assign max_x           = max_x_in;
   assign max_y           = max_v_in;
   assign flags.min_first = (min_p_in <= max_p_in);
   assign flags.rec_end   = record_end;

endmodule
`default_nettype wire

FILE: sv/mmbd_queue.sv
// Small FIFO of closed buckets between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module mmbd_queue #(
   parameter int WIDTH = 98,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  full,
   output logic                  empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    bank_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = bank_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         bank_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_BITS'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_BITS'(1);
         end
      end
   end

endmodule
`default_nettype wire

FILE: sv/mmbd_back.sv
// Back end: splits each closed bucket into its two ordered points on the output register.
`timescale 1ns / 1ps
`default_nettype none
module mmbd_back
   import mmbd_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int POS_BITS    = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          empty,
   input  wire logic [POS_BITS-1:0]           min_x,
   input  wire logic signed [SAMPLE_BITS-1:0] min_y,
   input  wire logic [POS_BITS-1:0]           max_x,
   input  wire logic signed [SAMPLE_BITS-1:0] max_y,
   input  wire mmbd_flags_type                flags,
   output logic                               pop,
   input  wire logic                          rsp_stall,
   output logic                               rsp_valid,
   output logic [POS_BITS-1:0]                rsp_x_out,
   output logic signed [SAMPLE_BITS-1:0]      rsp_y_out,
   output logic                               rsp_pair_last,
   output logic                               rsp_record_last
);

   logic                          phase_ff;
   logic                          valid_ff;
   logic [POS_BITS-1:0]           x_ff;
   logic signed [SAMPLE_BITS-1:0] y_ff;
   logic                          pair_last_ff;
   logic                          record_last_ff;
   logic                          load;
   logic                          take_min;

   assign load     = !empty && (!valid_ff || !rsp_stall);
   assign pop      = load && phase_ff;
   assign take_min = flags.min_first ^ phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            phase_ff <= !phase_ff;
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff           <= take_min ? min_x : max_x;
         y_ff           <= take_min ? min_y : max_y;
         pair_last_ff   <= phase_ff;
         record_last_ff <= phase_ff && flags.rec_end;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_x_out       = x_ff;
   assign rsp_y_out       = y_ff;
   assign rsp_pair_last   = pair_last_ff;
   assign rsp_record_last = record_last_ff;

endmodule
`default_nettype wire

FILE: sv/minmax_bucket_decimator.sv
// Top level of the min/max bucket decimator.
// Takes one sample word per cycle while the queue is not full. A sample that closes a bucket
// (by count, or by record_end) produces two result words, min/max in position order; the output
// register sends one word per cycle while rsp_stall is low. A four-entry queue of closed buckets
// sits between the sampling front end and the output back end: sustained input rate is one
// sample per cycle while buckets hold two or more samples, and is set by the output port while
// every sample closes a bucket (bucket size of one, or one-sample records).
`timescale 1ns / 1ps
`default_nettype none
module minmax_bucket_decimator
   import mmbd_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int POS_BITS    = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_en,
   input  wire logic [CSR_IDX_BITS-1:0]       csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [POS_BITS-1:0]           req_x_pos,
   input  wire logic signed [SAMPLE_BITS-1:0] req_y_sample,
   input  wire logic                          req_record_end,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [POS_BITS-1:0]                rsp_x_out,
   output logic signed [SAMPLE_BITS-1:0]      rsp_y_out,
   output logic                               rsp_pair_last,
   output logic                               rsp_record_last
);

   localparam int FLAG_BITS  = $bits(mmbd_flags_type);
   localparam int ENTRY_BITS = 2 * POS_BITS + 2 * SAMPLE_BITS + FLAG_BITS;

   logic                          accept;
   logic                          push;
   logic                          pop;
   logic                          full;
   logic                          empty;
   logic [POS_BITS-1:0]           f_min_x;
   logic signed [SAMPLE_BITS-1:0] f_min_y;
   logic [POS_BITS-1:0]           f_max_x;
   logic signed [SAMPLE_BITS-1:0] f_max_y;
   mmbd_flags_type                f_flags;
   logic [POS_BITS-1:0]           b_min_x;
   logic signed [SAMPLE_BITS-1:0] b_min_y;
   logic [POS_BITS-1:0]           b_max_x;
   logic signed [SAMPLE_BITS-1:0] b_max_y;
   mmbd_flags_type                b_flags;
   logic [ENTRY_BITS-1:0]         push_data;
   logic [ENTRY_BITS-1:0]         pop_data;

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;
   assign push_data = {f_min_x, f_min_y, f_max_x, f_max_y, f_flags};
   assign {b_min_x, b_min_y, b_max_x, b_max_y, b_flags} = pop_data;

   mmbd_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .POS_BITS    (POS_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .x_pos        (req_x_pos),
      .y_sample     (req_y_sample),
      .record_end   (req_record_end),
      .push         (push),
      .min_x        (f_min_x),
      .min_y        (f_min_y),
      .max_x        (f_max_x),
      .max_y        (f_max_y),
      .flags        (f_flags)
   );

   mmbd_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (4)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (full),
      .empty     (empty)
   );

   mmbd_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .POS_BITS    (POS_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .empty           (empty),
      .min_x           (b_min_x),
      .min_y           (b_min_y),
      .max_x           (b_max_x),
      .max_y           (b_max_y),
      .flags           (b_flags),
      .pop             (pop),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_x_out       (rsp_x_out),
      .rsp_y_out       (rsp_y_out),
      .rsp_pair_last   (rsp_pair_last),
      .rsp_record_last (rsp_record_last)
   );

endmodule
`default_nettype wire

FILE: sv/mmbd_checker.sv
// Port-level assertions for the min/max bucket decimator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mmbd_checker #(
   parameter int SAMPLE_BITS = 16,
   parameter int POS_BITS    = 32
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   req_record_end,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [POS_BITS-1:0]    rsp_x_out,
   input wire logic [SAMPLE_BITS-1:0] rsp_y_out,
   input wire logic                   rsp_pair_last,
   input wire logic                   rsp_record_last
);

   logic       second_ff;
   logic [3:0] rec_pend_ff;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff   <= 1'b0;
         rec_pend_ff <= '0;
      end else begin
         if (rsp_take) begin
            second_ff <= !second_ff;
         end
         if ((req_take && req_record_end) && !(rsp_take && rsp_record_last)) begin
            rec_pend_ff <= rec_pend_ff + 4'd1;
         end else if (!(req_take && req_record_end) && (rsp_take && rsp_record_last)) begin
            rec_pend_ff <= rec_pend_ff - 4'd1;
         end
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pair_last == second_ff))
      else $error("pair_last out of step with word count");

   a_record_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_record_last) |-> (rsp_pair_last && rec_pend_ff != 4'd0))
      else $error("record_last without pending record end");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_x_out) && $stable(rsp_y_out) &&
          $stable(rsp_pair_last) && $stable(rsp_record_last)))
      else $error("stalled result word changed");

endmodule

bind minmax_bucket_decimator mmbd_checker #(
   .SAMPLE_BITS (SAMPLE_BITS),
   .POS_BITS    (POS_BITS)
) u_mmbd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_record_end  (req_record_end),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_x_out       (rsp_x_out),
   .rsp_y_out       (rsp_y_out),
   .rsp_pair_last   (rsp_pair_last),
   .rsp_record_last (rsp_record_last)
);
`default_nettype wire
